[sv/ecpad_pkg.sv]
package ecpad_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEFF_A     = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_PRIME = 1'b1;

    localparam int MIN_PRIME   = 3;
    localparam int CONST_THREE = 3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_WB,
        OP_ADD,
        OP_SUB,
        OP_INVINIT,
        OP_ESHIFT,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        R_X1,
        R_Y1,
        R_X2,
        R_Y2,
        R_A,
        R_T,
        R_U,
        R_L,
        R_IR,
        R_IB,
        R_ONE,
        R_C3
    } reg_sel_t;

    typedef enum logic [1:0] {
        OUT_INF,
        OUT_P,
        OUT_Q,
        OUT_R
    } out_sel_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t dst;
        reg_sel_t src_a;
        reg_sel_t src_b;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic x_eq;
        logic y_eq;
        logic y1_zero;
        logic e_zero;
        logic e_lsb;
        logic p_inf;
        logic q_inf;
        logic out_busy;
    } status_t;

endpackage

[sv/ecpad_mulmod.sv]
module ecpad_mulmod #(
    parameter int COORD_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] op_a,
    input  logic [COORD_BITS-1:0] op_b,
    input  logic [COORD_BITS-1:0] modulus,
    output logic                  done,
    output logic [COORD_BITS-1:0] result
);

    localparam int W  = COORD_BITS;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  m_reg;

    logic [W+1:0]  sum;
    logic [W+1:0]  sum_m;
    logic [W+1:0]  sum_2m;
    logic [W+1:0]  m_ext;
    logic [W-1:0]  r_next;

    // one double-and-add step: 2r + bit*a stays below 3m
    always_comb
    begin
        m_ext  = {2'b00, m_reg};
        sum    = {1'b0, r_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        sum_m  = sum - m_ext;
        sum_2m = sum - {m_ext[W:0], 1'b0};
        if (sum >= {m_ext[W:0], 1'b0})
            r_next = sum_2m[W-1:0];
        else if (sum >= m_ext)
            r_next = sum_m[W-1:0];
        else
            r_next = sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            a_reg <= op_a;
            b_reg <= op_b;
            m_reg <= modulus;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && busy_reg))
        else $error("multiply started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running multiply");
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < m_reg))
        else $error("product not reduced");

endmodule

[sv/ecpad_datapath.sv]
module ecpad_datapath #(
    parameter int COORD_BITS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ecpad_pkg::cmd_t                       cmd,
    output ecpad_pkg::status_t                    status,
    input  logic                                  cfg_we,
    input  logic [ecpad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_data,
    input  logic [COORD_BITS-1:0]                 p_x,
    input  logic [COORD_BITS-1:0]                 p_y,
    input  logic                                  p_infinite,
    input  logic [COORD_BITS-1:0]                 q_x,
    input  logic [COORD_BITS-1:0]                 q_y,
    input  logic                                  q_infinite,
    output logic [COORD_BITS-1:0]                 sum_x,
    output logic [COORD_BITS-1:0]                 sum_y,
    output logic                                  sum_infinite,
    output logic                                  out_valid,
    input  logic                                  out_ready
);

    localparam int W = COORD_BITS;

    logic [W-1:0] coeff_a_reg;
    logic [W-1:0] prime_reg;
    logic [W-1:0] m_reg;
    logic [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, a_reg;
    logic [W-1:0] t_reg, u_reg, l_reg, ir_reg, ib_reg, e_reg;
    logic         pinf_reg, qinf_reg;
    logic [W-1:0] sum_x_reg, sum_y_reg;
    logic         sum_inf_reg;
    logic         out_valid_reg;

    logic [W-1:0] opa, opb;
    logic [W:0]   add_s;
    logic [W-1:0] wr_next;
    logic         wr_en;
    logic         mul_done;
    logic [W-1:0] mul_res;

    function automatic logic [W-1:0] pick(ecpad_pkg::reg_sel_t s);
        logic [W-1:0] v;
        case (s)
            ecpad_pkg::R_X1:  v = x1_reg;
            ecpad_pkg::R_Y1:  v = y1_reg;
            ecpad_pkg::R_X2:  v = x2_reg;
            ecpad_pkg::R_Y2:  v = y2_reg;
            ecpad_pkg::R_A:   v = a_reg;
            ecpad_pkg::R_T:   v = t_reg;
            ecpad_pkg::R_U:   v = u_reg;
            ecpad_pkg::R_L:   v = l_reg;
            ecpad_pkg::R_IR:  v = ir_reg;
            ecpad_pkg::R_IB:  v = ib_reg;
            ecpad_pkg::R_ONE: v = W'(1);
            ecpad_pkg::R_C3:  v = (m_reg == W'(ecpad_pkg::CONST_THREE)) ? '0
                                  : W'(ecpad_pkg::CONST_THREE);
            default:          v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(cmd.src_a);
    assign opb = pick(cmd.src_b);

    ecpad_mulmod #(.COORD_BITS(W)) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == ecpad_pkg::OP_MUL),
        .op_a    (opa),
        .op_b    (opb),
        .modulus (m_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_comb
    begin
        add_s   = {1'b0, opa} + {1'b0, opb};
        wr_en   = 1'b0;
        wr_next = mul_res;
        case (cmd.op)
            ecpad_pkg::OP_WB:
            begin
                wr_en   = mul_done;
                wr_next = mul_res;
            end
            ecpad_pkg::OP_ADD:
            begin
                wr_en   = 1'b1;
                wr_next = (add_s >= {1'b0, m_reg}) ? W'(add_s - {1'b0, m_reg})
                                                   : add_s[W-1:0];
            end
            ecpad_pkg::OP_SUB:
            begin
                wr_en   = 1'b1;
                wr_next = (opa >= opb) ? (opa - opb) : (opa - opb + m_reg);
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_next = mul_res;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_a_reg   <= '0;
            prime_reg     <= W'(ecpad_pkg::MIN_PRIME);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ecpad_pkg::CFG_COEFF_A:     coeff_a_reg <= cfg_data;
                    ecpad_pkg::CFG_FIELD_PRIME: prime_reg   <= cfg_data;
                    default:                    ;
                endcase
            end
            if (cmd.op == ecpad_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ecpad_pkg::OP_LOAD:
            begin
                x1_reg   <= p_x;
                y1_reg   <= p_y;
                x2_reg   <= q_x;
                y2_reg   <= q_y;
                a_reg    <= coeff_a_reg;
                pinf_reg <= p_infinite;
                qinf_reg <= q_infinite;
                m_reg    <= (prime_reg < W'(ecpad_pkg::MIN_PRIME))
                            ? W'(ecpad_pkg::MIN_PRIME) : prime_reg;
            end
            ecpad_pkg::OP_INVINIT:
            begin
                ir_reg <= W'(1);
                ib_reg <= u_reg;
                e_reg  <= m_reg - W'(2);
            end
            ecpad_pkg::OP_ESHIFT:
                e_reg <= {1'b0, e_reg[W-1:1]};
            ecpad_pkg::OP_OUT:
            begin
                case (cmd.out_sel)
                    ecpad_pkg::OUT_P:
                    begin
                        sum_x_reg <= x1_reg; sum_y_reg <= y1_reg; sum_inf_reg <= 1'b0;
                    end
                    ecpad_pkg::OUT_Q:
                    begin
                        sum_x_reg <= x2_reg; sum_y_reg <= y2_reg; sum_inf_reg <= 1'b0;
                    end
                    ecpad_pkg::OUT_R:
                    begin
                        sum_x_reg <= u_reg; sum_y_reg <= t_reg; sum_inf_reg <= 1'b0;
                    end
                    default:
                    begin
                        sum_x_reg <= '0; sum_y_reg <= '0; sum_inf_reg <= 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
        if (wr_en)
        begin
            case (cmd.dst)
                ecpad_pkg::R_X1: x1_reg <= wr_next;
                ecpad_pkg::R_Y1: y1_reg <= wr_next;
                ecpad_pkg::R_X2: x2_reg <= wr_next;
                ecpad_pkg::R_Y2: y2_reg <= wr_next;
                ecpad_pkg::R_A:  a_reg  <= wr_next;
                ecpad_pkg::R_T:  t_reg  <= wr_next;
                ecpad_pkg::R_U:  u_reg  <= wr_next;
                ecpad_pkg::R_L:  l_reg  <= wr_next;
                ecpad_pkg::R_IR: ir_reg <= wr_next;
                ecpad_pkg::R_IB: ib_reg <= wr_next;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.mul_done = mul_done;
        status.x_eq     = (x1_reg == x2_reg);
        status.y_eq     = (y1_reg == y2_reg);
        status.y1_zero  = (y1_reg == '0);
        status.e_zero   = (e_reg == '0);
        status.e_lsb    = e_reg[0];
        status.p_inf    = pinf_reg;
        status.q_inf    = qinf_reg;
        status.out_busy = out_valid_reg && !out_ready;
    end

    assign sum_x        = sum_x_reg;
    assign sum_y        = sum_y_reg;
    assign sum_infinite = sum_inf_reg;
    assign out_valid    = out_valid_reg;

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ecpad_pkg::OP_OUT) |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

endmodule

[sv/ecpad_ctrl.sv]
module ecpad_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ecpad_pkg::status_t status,
    output ecpad_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_RA, S_RX1, S_RY1, S_RX2, S_RY2, S_DECIDE,
        S_D1, S_D2, S_D3, S_D4, S_A1, S_A2,
        S_I0, S_I1, S_I2, S_I3, S_I4,
        S_L, S_X1, S_X2, S_X3, S_Y1, S_Y2, S_Y3, S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                wait_reg, wait_next;
    ecpad_pkg::out_sel_t out_sel_reg, out_sel_next;

    logic                is_mul;
    state_t              after;

    always_comb
    begin
        cmd.op      = ecpad_pkg::OP_NOP;
        cmd.dst     = ecpad_pkg::R_T;
        cmd.src_a   = ecpad_pkg::R_ONE;
        cmd.src_b   = ecpad_pkg::R_ONE;
        cmd.out_sel = out_sel_reg;
        is_mul      = 1'b0;
        after       = state_reg;
        out_sel_next = out_sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = ecpad_pkg::OP_LOAD;
                    after  = S_RA;
                end
            end
            S_RA:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_A; cmd.src_b = ecpad_pkg::R_A;
                after = S_RX1;
            end
            S_RX1:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_X1; cmd.src_b = ecpad_pkg::R_X1;
                after = S_RY1;
            end
            S_RY1:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_Y1; cmd.src_b = ecpad_pkg::R_Y1;
                after = S_RX2;
            end
            S_RX2:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_X2; cmd.src_b = ecpad_pkg::R_X2;
                after = S_RY2;
            end
            S_RY2:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_Y2; cmd.src_b = ecpad_pkg::R_Y2;
                after = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.p_inf && status.q_inf)
                begin
                    out_sel_next = ecpad_pkg::OUT_INF; after = S_OUT;
                end
                else if (status.p_inf)
                begin
                    out_sel_next = ecpad_pkg::OUT_Q; after = S_OUT;
                end
                else if (status.q_inf)
                begin
                    out_sel_next = ecpad_pkg::OUT_P; after = S_OUT;
                end
                else if (status.x_eq)
                begin
                    // vertical line or tangent at y = 0
                    if (!status.y_eq || status.y1_zero)
                    begin
                        out_sel_next = ecpad_pkg::OUT_INF; after = S_OUT;
                    end
                    else
                        after = S_D1;
                end
                else
                    after = S_A1;
            end
            S_D1:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_C3; cmd.src_b = ecpad_pkg::R_X1; after = S_D2;
            end
            S_D2:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_T; cmd.src_b = ecpad_pkg::R_X1; after = S_D3;
            end
            S_D3:
            begin
                cmd.op = ecpad_pkg::OP_ADD; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_T; cmd.src_b = ecpad_pkg::R_A; after = S_D4;
            end
            S_D4:
            begin
                cmd.op = ecpad_pkg::OP_ADD; cmd.dst = ecpad_pkg::R_U;
                cmd.src_a = ecpad_pkg::R_Y1; cmd.src_b = ecpad_pkg::R_Y1; after = S_I0;
            end
            S_A1:
            begin
                cmd.op = ecpad_pkg::OP_SUB; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_Y2; cmd.src_b = ecpad_pkg::R_Y1; after = S_A2;
            end
            S_A2:
            begin
                cmd.op = ecpad_pkg::OP_SUB; cmd.dst = ecpad_pkg::R_U;
                cmd.src_a = ecpad_pkg::R_X2; cmd.src_b = ecpad_pkg::R_X1; after = S_I0;
            end
            S_I0:
            begin
                cmd.op = ecpad_pkg::OP_INVINIT; after = S_I1;
            end
            S_I1:
            begin
                if (status.e_zero)
                    after = S_L;
                else if (status.e_lsb)
                    after = S_I2;
                else
                    after = S_I3;
            end
            S_I2:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_IR;
                cmd.src_a = ecpad_pkg::R_IR; cmd.src_b = ecpad_pkg::R_IB; after = S_I3;
            end
            S_I3:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_IB;
                cmd.src_a = ecpad_pkg::R_IB; cmd.src_b = ecpad_pkg::R_IB; after = S_I4;
            end
            S_I4:
            begin
                cmd.op = ecpad_pkg::OP_ESHIFT; after = S_I1;
            end
            S_L:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_L;
                cmd.src_a = ecpad_pkg::R_T; cmd.src_b = ecpad_pkg::R_IR; after = S_X1;
            end
            S_X1:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_U;
                cmd.src_a = ecpad_pkg::R_L; cmd.src_b = ecpad_pkg::R_L; after = S_X2;
            end
            S_X2:
            begin
                cmd.op = ecpad_pkg::OP_SUB; cmd.dst = ecpad_pkg::R_U;
                cmd.src_a = ecpad_pkg::R_U; cmd.src_b = ecpad_pkg::R_X1; after = S_X3;
            end
            S_X3:
            begin
                cmd.op = ecpad_pkg::OP_SUB; cmd.dst = ecpad_pkg::R_U;
                cmd.src_a = ecpad_pkg::R_U; cmd.src_b = ecpad_pkg::R_X2; after = S_Y1;
            end
            S_Y1:
            begin
                cmd.op = ecpad_pkg::OP_SUB; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_X1; cmd.src_b = ecpad_pkg::R_U; after = S_Y2;
            end
            S_Y2:
            begin
                is_mul = 1'b1; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_L; cmd.src_b = ecpad_pkg::R_T; after = S_Y3;
            end
            S_Y3:
            begin
                cmd.op = ecpad_pkg::OP_SUB; cmd.dst = ecpad_pkg::R_T;
                cmd.src_a = ecpad_pkg::R_T; cmd.src_b = ecpad_pkg::R_Y1;
                out_sel_next = ecpad_pkg::OUT_R; after = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.op = ecpad_pkg::OP_OUT; after = S_IDLE;
                end
            end
            default: after = S_IDLE;
        endcase

        state_next = after;
        wait_next  = wait_reg;
        if (is_mul)
        begin
            if (!wait_reg)
            begin
                cmd.op     = ecpad_pkg::OP_MUL;
                wait_next  = 1'b1;
                state_next = state_reg;
            end
            else
            begin
                cmd.op = ecpad_pkg::OP_WB;
                if (status.mul_done)
                    wait_next = 1'b0;
                else
                    state_next = state_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wait_reg    <= 1'b0;
            out_sel_reg <= ecpad_pkg::OUT_INF;
        end
        else
        begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            out_sel_reg <= out_sel_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[sv/ec_point_add_double.sv]
// Work per transaction: 5 input reductions and up to 2*COORD_BITS+4 modular multiplies,
// all on one shared bit-serial multiplier, plus up to 2*COORD_BITS+11 other steps;
// fewer when a point is infinite or the prime is small.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset (rst_n, async, active low): curve_coeff_a = 0, field_prime = 3, control idle.
module ec_point_add_double #(
    parameter int COORD_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ecpad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [COORD_BITS-1:0]                p_x,
    input  logic [COORD_BITS-1:0]                p_y,
    input  logic                                 p_infinite,
    input  logic [COORD_BITS-1:0]                q_x,
    input  logic [COORD_BITS-1:0]                q_y,
    input  logic                                 q_infinite,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [COORD_BITS-1:0]                sum_x,
    output logic [COORD_BITS-1:0]                sum_y,
    output logic                                 sum_infinite
);

    ecpad_pkg::cmd_t    cmd;
    ecpad_pkg::status_t status;

    ecpad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ecpad_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .p_x          (p_x),
        .p_y          (p_y),
        .p_infinite   (p_infinite),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_infinite   (q_infinite),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .sum_infinite (sum_infinite),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule

[test/ec_point_add_double_checker.sv]
module ec_point_add_double_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ecpad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [63:0]                          cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [63:0]                          p_x,
    input  logic [63:0]                          p_y,
    input  logic                                 p_infinite,
    input  logic [63:0]                          q_x,
    input  logic [63:0]                          q_y,
    input  logic                                 q_infinite,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [63:0]                          sum_x,
    input  logic [63:0]                          sum_y,
    input  logic                                 sum_infinite,
    output int                                   errors,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
        logic        inf;
    } point_t;

    logic [63:0] coeff_a;
    logic [63:0] prime;
    point_t      sum_queue[$];

    function automatic logic [63:0] add_mod(logic [63:0] u, logic [63:0] v, logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[63:0];
    endfunction

    function automatic logic [63:0] sub_mod(logic [63:0] u, logic [63:0] v, logic [63:0] m);
        return (u >= v) ? u - v : u + (m - v);
    endfunction

    function automatic logic [63:0] mul_mod(logic [63:0] u, logic [63:0] v, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, u} * {64'd0, v};
        prod = prod % {64'd0, m};
        return prod[63:0];
    endfunction

    function automatic logic [63:0] inv_mod(logic [63:0] v, logic [63:0] m);
        logic [63:0] e;
        logic [63:0] r;
        logic [63:0] b;
        e = m - 64'd2;
        r = 64'd1;
        b = v;
        while (e != 0) begin
            if (e[0])
                r = mul_mod(r, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic point_t predict_sum(point_t p, point_t q);
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] x1, y1, x2, y2, lam, num, den, x3, y3;
        point_t      r;
        m = (prime < ecpad_pkg::MIN_PRIME) ? 64'(ecpad_pkg::MIN_PRIME) : prime;
        a = coeff_a % m;
        x1 = p.x % m;
        y1 = p.y % m;
        x2 = q.x % m;
        y2 = q.y % m;
        r = '{x: 64'd0, y: 64'd0, inf: 1'b1};
        if (p.inf && q.inf)
            return r;
        if (p.inf)
            return '{x: x2, y: y2, inf: 1'b0};
        if (q.inf)
            return '{x: x1, y: y1, inf: 1'b0};
        if (x1 == x2) begin
            if (y1 != y2 || y1 == 0)
                return r;
            num = add_mod(mul_mod(mul_mod(64'(ecpad_pkg::CONST_THREE) % m, x1, m), x1, m),
                          a, m);
            den = add_mod(y1, y1, m);
            lam = mul_mod(num, inv_mod(den, m), m);
        end
        else begin
            lam = mul_mod(sub_mod(y2, y1, m), inv_mod(sub_mod(x2, x1, m), m), m);
        end
        x3 = sub_mod(sub_mod(mul_mod(lam, lam, m), x1, m), x2, m);
        y3 = sub_mod(mul_mod(lam, sub_mod(x1, x3, m), m), y1, m);
        return '{x: x3, y: y3, inf: 1'b0};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    always_ff @(posedge clk or negedge rst_n) begin
        point_t want;
        if (!rst_n) begin
            coeff_a <= 64'd0;
            prime   <= 64'd3;
            errors  = 0;
            pending <= 0;
            sum_queue.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == ecpad_pkg::CFG_COEFF_A)
                    coeff_a <= cfg_data;
                else if (cfg_index == ecpad_pkg::CFG_FIELD_PRIME)
                    prime <= cfg_data;
            end
            if (in_valid && in_ready)
                sum_queue.push_back(predict_sum('{p_x, p_y, p_infinite},
                                                '{q_x, q_y, q_infinite}));
            if (out_valid && out_ready) begin
                if (sum_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", sum_x, 64'd0);
                end
                else begin
                    want = sum_queue.pop_front();
                    if (sum_infinite !== want.inf)
                        report_mismatch("sum_infinite", 64'(sum_infinite), 64'(want.inf));
                    if (sum_x !== want.x)
                        report_mismatch("sum_x", sum_x, want.x);
                    if (sum_y !== want.y)
                        report_mismatch("sum_y", sum_y, want.y);
                end
            end
            pending <= sum_queue.size();
        end
    end

endmodule

[test/ec_point_add_double_test.sv]
module ec_point_add_double_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 40_000_000;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [ecpad_pkg::CFG_INDEX_BITS-1:0] cfg_index = ecpad_pkg::CFG_COEFF_A;
    logic [63:0]                          cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [63:0]                          p_x = '0, p_y = '0, q_x = '0, q_y = '0;
    logic                                 p_infinite = 1'b0, q_infinite = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [63:0]                          sum_x, sum_y;
    logic                                 sum_infinite;
    int                                   errors;
    int                                   pending;

    int          send_pct;
    int          recv_pct;
    bit          hold_req;
    longint      cycles;
    logic [63:0] cur_prime;

    ec_point_add_double #(.COORD_BITS(64)) uut (.*);

    ec_point_add_double_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_cnt;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                hold_cnt = 0;
                while (hold_cnt < 30000) begin
                    @(negedge clk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end
            out_ready = ($urandom_range(99) >= recv_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] below(logic [63:0] m);
        logic [63:0] eff;
        eff = (m < ecpad_pkg::MIN_PRIME) ? 64'(ecpad_pkg::MIN_PRIME) : m;
        return rand64() % eff;
    endfunction

    task automatic write_reg(logic [ecpad_pkg::CFG_INDEX_BITS-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == ecpad_pkg::CFG_FIELD_PRIME)
            cur_prime = val;
    endtask

    task automatic send_point(logic [63:0] px, logic [63:0] py, logic pinf,
                              logic [63:0] qx, logic [63:0] qy, logic qinf);
        while ($urandom_range(99) < send_pct) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        p_x = px;
        p_y = py;
        p_infinite = pinf;
        q_x = qx;
        q_y = qy;
        q_infinite = qinf;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random(int n);
        logic [63:0] x1, y1, x2, y2;
        int          kind;
        repeat (n) begin
            kind = $urandom_range(99);
            x1 = below(cur_prime);
            y1 = below(cur_prime);
            x2 = below(cur_prime);
            y2 = below(cur_prime);
            if (kind < 20) begin
                send_point(x1, y1, 1'b0, x1, y1, 1'b0);
            end
            else if (kind < 25) begin
                send_point(x1, y1, 1'b0, x1, y2, 1'b0);
            end
            else if (kind < 28) begin
                send_point(x1, 64'd0, 1'b0, x1, 64'd0, 1'b0);
            end
            else if (kind < 38) begin
                send_point(x1, y1, 1'($urandom_range(1)), x2, y2, 1'($urandom_range(1)));
            end
            else if (kind < 48) begin
                send_point(rand64(), rand64(), 1'b0, rand64(), rand64(), 1'b0);
            end
            else begin
                send_point(x1, y1, 1'b0, x2, y2, 1'b0);
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0 || out_valid)
            @(negedge clk);
    endtask

    task automatic set_mode(int phase);
        case (phase % 4)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 73; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 73; end
            default: begin send_pct = 26; recv_pct = 26; end
        endcase
    endtask

    task automatic run_phase(int phase, logic [63:0] a, logic [63:0] m, int n);
        drain();
        write_reg(ecpad_pkg::CFG_COEFF_A, a);
        write_reg(ecpad_pkg::CFG_FIELD_PRIME, m);
        set_mode(phase);
        send_random(n);
    endtask

    initial
    begin
        send_pct = 0;
        recv_pct = 0;
        hold_req = 1'b0;
        cycles = 0;
        cur_prime = 64'd3;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of the registers
        send_random(30);

        drain();
        write_reg(ecpad_pkg::CFG_COEFF_A, 64'd2);
        write_reg(ecpad_pkg::CFG_FIELD_PRIME, 64'd97);
        send_point(64'd5, 64'd7, 1'b1, 64'd9, 64'd11, 1'b1);
        send_point(64'd5, 64'd7, 1'b1, 64'd9, 64'd11, 1'b0);
        send_point(64'd5, 64'd7, 1'b0, 64'd9, 64'd11, 1'b1);
        send_point(64'd200, 64'd300, 1'b1, 64'd400, 64'd500, 1'b0);
        send_point(64'd3, 64'd6, 1'b0, 64'd3, 64'd6, 1'b0);
        send_point(64'd10, 64'd0, 1'b0, 64'd10, 64'd0, 1'b0);
        send_point(64'd10, 64'd0, 1'b0, 64'd107, 64'd97, 1'b0);
        send_point(64'd10, 64'd4, 1'b0, 64'd10, 64'd93, 1'b0);
        send_point(64'd1, 64'd2, 1'b0, 64'd4, 64'd8, 1'b0);
        send_point(64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 1'b0);
        send_point(64'd96, 64'd96, 1'b0, 64'd96, 64'd96, 1'b0);
        send_point(64'd96, 64'd96, 1'b0, 64'd0, 64'd1, 1'b0);
        send_point('1, '1, 1'b0, '1, '1, 1'b0);
        send_point('1, '1, 1'b0, 64'd0, 64'd0, 1'b0);
        send_point('1, 64'd0, 1'b0, 64'd0, '1, 1'b1);
        send_point(64'd0, '1, 1'b1, '1, 64'd0, 1'b0);
        send_point(64'd194, 64'd30, 1'b0, 64'd0, 64'd127, 1'b0);
        send_point(64'd20, 64'd33, 1'b0, 64'd117, 64'd130, 1'b0);
        send_random(60);

        run_phase(1, '1, 64'd2, 40);
        run_phase(2, rand64(), 64'd7, 60);
        run_phase(3, rand64(), 64'd65521, 70);
        run_phase(4, 64'd5, 64'd15, 40);
        run_phase(5, rand64(), 64'd0, 30);
        run_phase(6, rand64(), 64'd1000003, 70);
        run_phase(7, rand64(), 64'd4294967291, 50);
        run_phase(8, rand64(), 64'hFFFF_FFFF_FFFF_FFC5, 30);
        run_phase(9, rand64(), '1, 20);
        drain();
        write_reg(ecpad_pkg::CFG_COEFF_A, 64'd0);
        write_reg(ecpad_pkg::CFG_FIELD_PRIME, 64'd13);
        set_mode(2);
        // hold the receiver off while items keep coming so the input stalls
        hold_req = 1'b1;
        send_random(60);
        run_phase(11, rand64(), 64'd11, 80);
        run_phase(12, rand64(), 64'd1, 30);

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
